/* rtl/brx_pkg.sv */
// Shared types and constants for the block transfer receiver.
// No dependencies; compile this file first.
package brx_pkg;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_LEN  = 3'd1,
        PH_DATA = 3'd2,
        PH_SUM  = 3'd3,
        PH_EOT  = 3'd4
    } phase_t;

    typedef enum logic {
        MODE_START = 1'b0,
        MODE_BYTE  = 1'b1
    } mode_t;

    localparam logic [2:0] ST_BUSY     = 3'd0;
    localparam logic [2:0] ST_DONE     = 3'd1;
    localparam logic [2:0] ST_SUM_ERR  = 3'd2;
    localparam logic [2:0] ST_LEN_ERR  = 3'd3;
    localparam logic [2:0] ST_EOT_ERR  = 3'd4;

    localparam logic [7:0] CHR_EOT = 8'h04;

    typedef struct packed {
        logic       send_ack;
        logic       data_valid;
        logic [7:0] payload_byte;
        logic       block_commit;
        logic [2:0] status;
        logic [7:0] sent_sum;
        logic [7:0] computed_sum;
    } result_t;

endpackage

/* rtl/brx_item_if.sv */
// Input channel of the block transfer receiver: valid/ready plus one request.
// Depends on nothing.
interface brx_item_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] rx_byte;

    modport source (output valid, output mode, output rx_byte, input ready);
    modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

/* rtl/brx_result_if.sv */
// Result channel of the block transfer receiver: valid/ready plus result fields.
// Depends on nothing.
interface brx_result_if;
    logic       valid;
    logic       ready;
    logic       send_ack;
    logic       data_valid;
    logic [7:0] payload_byte;
    logic       block_commit;
    logic [2:0] status;
    logic [7:0] sent_sum;
    logic [7:0] computed_sum;

    modport source (output valid, output send_ack, output data_valid, output payload_byte,
                    output block_commit, output status, output sent_sum,
                    output computed_sum, input ready);
    modport sink   (input valid, input send_ack, input data_valid, input payload_byte,
                    input block_commit, input status, input sent_sum,
                    input computed_sum, output ready);
endinterface

/* rtl/block_transfer_receiver_unit.sv */
// Top level of the block transfer receiver (length/data/checksum blocks, ACK/EOT).
// Depends on brx_pkg, brx_item_if and brx_result_if.
//
// Usage:
//   item   : requests in. mode 0 starts a transfer, mode 1 carries one received byte.
//   result : at most one result per request; bytes that arrive while idle give none.
//   cfg_wr_en/cfg_wr_data : write expected_size (total payload bytes); write only
//            while no request is in flight.
// Result path: the result of an accepted request is registered in the output register,
//   or in the skid register while the output register is stalled.
// Throughput: one request per cycle while item.ready is high. The phase and counter
//   update is a single pass through one 33-bit add and compare; a full skid register stops requests.
// Stall: a result that cannot leave is held in the output register; one more
//   result fits in a skid register, after which item.ready drops until the
//   output register drains.
// Reset: rst_n clears the phase to idle, all counters, expected_size and the
//   valid flags of both result registers; item.ready is high right after reset.
module block_transfer_receiver_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [31:0]  cfg_wr_data,
    brx_item_if.sink     item,
    brx_result_if.source result
);

    brx_pkg::phase_t  phase_reg, phase_next;
    logic [31:0]      expected_size_reg;
    logic [31:0]      received_total_reg, received_total_next;
    logic [7:0]       block_length_reg, block_length_next;
    logic [7:0]       bytes_left_reg, bytes_left_next;
    logic [7:0]       running_sum_reg, running_sum_next;

    brx_pkg::result_t res_next;
    logic             res_has;
    logic             out_valid_reg;
    brx_pkg::result_t out_data_reg;
    logic             skid_valid_reg;
    brx_pkg::result_t skid_data_reg;

    logic             accept;
    logic             out_fire;
    logic [32:0]      total_sum;
    logic             checksum_ok;

    assign item.ready  = ~skid_valid_reg;
    assign accept      = item.valid & item.ready;
    assign out_fire    = out_valid_reg & result.ready;
    assign total_sum   = {1'b0, received_total_reg} + {25'd0, block_length_reg};
    assign checksum_ok = (item.rx_byte == running_sum_reg);

    // Next state and counters
    always_comb
    begin
        phase_next          = phase_reg;
        received_total_next = received_total_reg;
        block_length_next   = block_length_reg;
        bytes_left_next     = bytes_left_reg;
        running_sum_next    = running_sum_reg;
        if (item.mode == brx_pkg::MODE_START)
        begin
            received_total_next = '0;
            block_length_next   = '0;
            bytes_left_next     = '0;
            running_sum_next    = '0;
            phase_next = (expected_size_reg == '0) ? brx_pkg::PH_EOT : brx_pkg::PH_LEN;
        end
        else
        begin
            unique case (phase_reg)
                brx_pkg::PH_LEN:
                begin
                    block_length_next = item.rx_byte;
                    bytes_left_next   = item.rx_byte;
                    running_sum_next  = '0;
                    phase_next = (item.rx_byte == '0) ? brx_pkg::PH_SUM : brx_pkg::PH_DATA;
                end
                brx_pkg::PH_DATA:
                begin
                    running_sum_next = running_sum_reg + item.rx_byte;
                    bytes_left_next  = bytes_left_reg - 8'd1;
                    if (bytes_left_reg == 8'd1)
                    begin
                        phase_next = brx_pkg::PH_SUM;
                    end
                end
                brx_pkg::PH_SUM:
                begin
                    if (!checksum_ok || total_sum > {1'b0, expected_size_reg})
                    begin
                        phase_next = brx_pkg::PH_IDLE;
                    end
                    else
                    begin
                        received_total_next = total_sum[31:0];
                        phase_next = (total_sum[31:0] == expected_size_reg) ?
                                     brx_pkg::PH_EOT : brx_pkg::PH_LEN;
                    end
                end
                brx_pkg::PH_EOT:
                begin
                    phase_next = brx_pkg::PH_IDLE;
                end
                default:
                begin
                    phase_next = brx_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // Result of the current request
    always_comb
    begin
        res_next = '0;
        res_has  = 1'b1;
        if (item.mode == brx_pkg::MODE_START)
        begin
            res_next.send_ack = 1'b1;
        end
        else
        begin
            unique case (phase_reg)
                brx_pkg::PH_LEN:
                begin
                    res_next.status = brx_pkg::ST_BUSY;
                end
                brx_pkg::PH_DATA:
                begin
                    res_next.data_valid   = 1'b1;
                    res_next.payload_byte = item.rx_byte;
                end
                brx_pkg::PH_SUM:
                begin
                    if (!checksum_ok)
                    begin
                        res_next.status       = brx_pkg::ST_SUM_ERR;
                        res_next.sent_sum     = item.rx_byte;
                        res_next.computed_sum = running_sum_reg;
                    end
                    else
                    begin
                        res_next.block_commit = 1'b1;
                        if (total_sum > {1'b0, expected_size_reg})
                        begin
                            res_next.status = brx_pkg::ST_LEN_ERR;
                        end
                        else
                        begin
                            res_next.send_ack = 1'b1;
                        end
                    end
                end
                brx_pkg::PH_EOT:
                begin
                    if (item.rx_byte == brx_pkg::CHR_EOT)
                    begin
                        res_next.send_ack = 1'b1;
                        res_next.status   = brx_pkg::ST_DONE;
                    end
                    else
                    begin
                        res_next.status = brx_pkg::ST_EOT_ERR;
                    end
                end
                default:
                begin
                    // drop bytes while idle
                    res_has = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_size_reg  <= '0;
            phase_reg          <= brx_pkg::PH_IDLE;
            received_total_reg <= '0;
            block_length_reg   <= '0;
            bytes_left_reg     <= '0;
            running_sum_reg    <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                expected_size_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                phase_reg          <= phase_next;
                received_total_reg <= received_total_next;
                block_length_reg   <= block_length_next;
                bytes_left_reg     <= bytes_left_next;
                running_sum_reg    <= running_sum_next;
            end
        end
    end

    // Output register with one skid entry behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (!out_valid_reg || out_fire)
        begin
            out_valid_reg <= accept & res_has;
        end
        else if (accept && res_has)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (!out_valid_reg || out_fire)
        begin
            out_data_reg <= res_next;
        end
        else
        begin
            skid_data_reg <= res_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.send_ack     = out_data_reg.send_ack;
    assign result.data_valid   = out_data_reg.data_valid;
    assign result.payload_byte = out_data_reg.payload_byte;
    assign result.block_commit = out_data_reg.block_commit;
    assign result.status       = out_data_reg.status;
    assign result.sent_sum     = out_data_reg.sent_sum;
    assign result.computed_sum = out_data_reg.computed_sum;

endmodule
